// ===== src/ncs_pkg.sv =====
// Shared constants for the nearest codeword search block.
// Holds port widths, configuration register indexes and reset values.
// No dependencies.
`default_nettype none

package ncs_pkg;

	// Fixed field widths of the request and result channels
	localparam int ROW_BITS = 10;
	localparam int COL_BITS = 4;

	// Configuration port
	localparam int ROWS_CFG_BITS  = 11;
	localparam int DIMS_CFG_BITS  = 5;
	localparam int CFG_DATA_BITS  = 11;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_ROWS_IN_USE = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DIMS_IN_USE = 1'd1;

	localparam logic [ROWS_CFG_BITS-1:0] ROWS_RESET = 11'd1024;
	localparam logic [DIMS_CFG_BITS-1:0] DIMS_RESET = 5'd16;

	// Request opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== src/ncs_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
`default_nettype none

module ncs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== src/nearest_codeword_search.sv =====
// Nearest codeword search: squared Euclidean nearest neighbor over a stored codebook.
// Operation: a codebook write or a non-final query element is stored. A final query
//   element starts a row-major scan of the codebook, a drain of the distance pipeline,
//   then dims results, each read from the codebook RAM and then loaded for output.
// Throughput: one codebook element per cycle during the scan, set by the single
//   read port of the codebook RAM. Reset: control and best-match state clear at
//   once; codebook and query RAMs hold garbage until written (no clearing pass).
// Depends on ncs_pkg and ncs_ram.
`default_nettype none

module nearest_codeword_search #(
	parameter int MAX_ROWS   = 1024,
	parameter int MAX_DIMS   = 16,
	parameter int VALUE_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration write port
	input  wire logic                               cfg_we,
	input  wire logic [ncs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [ncs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// request channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               op,
	input  wire logic [ncs_pkg::ROW_BITS-1:0]       row,
	input  wire logic [ncs_pkg::COL_BITS-1:0]       column,
	input  wire logic signed [VALUE_BITS-1:0]       value,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [ncs_pkg::ROW_BITS-1:0]            match_index,
	output logic [ncs_pkg::COL_BITS-1:0]            out_column,
	output logic signed [VALUE_BITS-1:0]            out_value,
	output logic                                    last
);

	import ncs_pkg::*;

	// Row and column index widths; a codebook row occupies a power-of-two slot
	// so the RAM address is just {row, column}.
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int AW    = RW + DW;
	localparam int CB_DEPTH = MAX_ROWS * (2 ** DW);
	localparam int RCW   = $clog2(MAX_ROWS + 1);
	localparam int DCW   = $clog2(MAX_DIMS + 1);
	// Difference needs one extra bit; its square fits 2*VALUE_BITS+1 bits.
	localparam int DFW   = VALUE_BITS + 1;
	localparam int SQW   = 2 * VALUE_BITS + 1;
	// Sum of up to MAX_DIMS squares.
	localparam int SW    = SQW + DCW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	// Tag that travels with each element through the distance pipeline
	typedef struct packed {
		logic          first;
		logic          last_d;
		logic [RW-1:0] row;
	} scan_tag_t;

	state_t state_q;

	logic [ROWS_CFG_BITS-1:0] cfg_rows_q;
	logic [DIMS_CFG_BITS-1:0] cfg_dims_q;

	logic [RW-1:0] scan_row_q;
	logic [DW-1:0] scan_d_q;
	logic [DW-1:0] emit_d_q;

	logic [RW-1:0] best_row_q;
	logic [SW-1:0] best_dist_q;

	logic                   out_valid_q;
	logic [ROW_BITS-1:0]    match_index_q;
	logic [COL_BITS-1:0]    out_column_q;
	logic [VALUE_BITS-1:0]  out_value_q;
	logic                   last_q;

	// ------------------------------------------------------------------
	// Clamp the configuration to the legal range and derive end markers
	// ------------------------------------------------------------------
	logic [RCW-1:0] rows_cl;
	logic [DCW-1:0] dims_cl;
	logic [RW-1:0]  rows_last;
	logic [DW-1:0]  dims_last;

	always_comb begin
		if (cfg_rows_q == '0) begin
			rows_cl = RCW'(1);
		end else if (int'(cfg_rows_q) > MAX_ROWS) begin
			rows_cl = RCW'(MAX_ROWS);
		end else begin
			rows_cl = RCW'(cfg_rows_q);
		end
		if (cfg_dims_q == '0) begin
			dims_cl = DCW'(1);
		end else if (int'(cfg_dims_q) > MAX_DIMS) begin
			dims_cl = DCW'(MAX_DIMS);
		end else begin
			dims_cl = DCW'(cfg_dims_q);
		end
		rows_last = RW'(rows_cl - 1'b1);
		dims_last = DW'(dims_cl - 1'b1);
	end

	// ------------------------------------------------------------------
	// Request decode: requests are taken only while idle
	// ------------------------------------------------------------------
	logic           in_acc;
	logic           row_ok;
	logic           col_ok;
	logic [RW+ROW_BITS-1:0] row_wide;
	logic [DW+COL_BITS-1:0] col_wide;
	logic [RW-1:0]  in_row;
	logic [DW-1:0]  in_col;
	logic           cb_we;
	logic           qb_we;
	logic           start_search;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	assign row_ok   = int'(row) < MAX_ROWS;
	assign col_ok   = int'(column) < MAX_DIMS;
	assign row_wide = (RW + ROW_BITS)'(row);
	assign col_wide = (DW + COL_BITS)'(column);
	assign in_row   = row_wide[RW-1:0];
	assign in_col   = col_wide[DW-1:0];

	// Drop writes that fall outside the store.
	assign cb_we        = in_acc && (op == OP_WRITE) && row_ok && col_ok;
	assign qb_we        = in_acc && (op == OP_QUERY) && col_ok;
	// Only the element at the last column in use kicks off a search.
	assign start_search = qb_we && (in_col == dims_last);

	// ------------------------------------------------------------------
	// Memories
	// ------------------------------------------------------------------
	logic [AW-1:0]         cb_raddr;
	logic [VALUE_BITS-1:0] cb_rdata;
	logic [VALUE_BITS-1:0] qb_rdata;
	logic                  emitting;

	assign emitting = (state_q == S_EMIT_RD) || (state_q == S_EMIT_LD);
	// Scan walks {row, column}; emission rereads the winning row, holding the
	// address steady while a stalled result waits.
	assign cb_raddr = emitting ? {best_row_q, emit_d_q} : {scan_row_q, scan_d_q};

	ncs_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (CB_DEPTH)
	) u_codebook (
		.clk     (clk),
		.wr_en   (cb_we),
		.wr_addr ({in_row, in_col}),
		.wr_data (value),
		.rd_addr (cb_raddr),
		.rd_data (cb_rdata)
	);

	ncs_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (MAX_DIMS)
	) u_query (
		.clk     (clk),
		.wr_en   (qb_we),
		.wr_addr (in_col),
		.wr_data (value),
		.rd_addr (scan_d_q),
		.rd_data (qb_rdata)
	);

	// ------------------------------------------------------------------
	// Distance pipeline
	//   s1: RAM read in flight
	//   s2: difference registered
	//   s3: square registered
	//   s4: running sum per row registered
	//   then the row sum is compared against the best so far
	// ------------------------------------------------------------------
	logic      scan_issue;
	logic      scan_end_d;
	logic      scan_end_r;
	logic      valid_s1, valid_s2, valid_s3, valid_s4;
	scan_tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [DFW-1:0]   diff_s2;
	logic signed [2*DFW-1:0] sq_full;
	logic [SQW-1:0]          sq_s3;
	logic [SW-1:0]           acc_s4;
	logic signed [DFW-1:0]   diff_next;
	logic                    pipe_empty;
	logic                    take_best;

	assign scan_issue = (state_q == S_SCAN);
	assign scan_end_d = (scan_d_q == dims_last);
	assign scan_end_r = (scan_row_q == rows_last);

	assign diff_next = $signed({cb_rdata[VALUE_BITS-1], cb_rdata})
		- $signed({qb_rdata[VALUE_BITS-1], qb_rdata});
	assign sq_full   = diff_s2 * diff_s2;
	assign pipe_empty = !valid_s1 && !valid_s2 && !valid_s3 && !valid_s4;
	// Strict less-than keeps the lower row on a tie; row 0 always seeds.
	assign take_best = valid_s4 && tag_s4.last_d
		&& ((tag_s4.row == '0) || (acc_s4 < best_dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			best_row_q  <= '0;
			best_dist_q <= '0;
		end else begin
			valid_s1 <= scan_issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (take_best) begin
				best_row_q  <= tag_s4.row;
				best_dist_q <= acc_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_s1.first  <= (scan_d_q == '0);
		tag_s1.last_d <= scan_end_d;
		tag_s1.row    <= scan_row_q;
		tag_s2        <= tag_s1;
		diff_s2       <= diff_next;
		tag_s3        <= tag_s2;
		sq_s3         <= sq_full[SQW-1:0];
		if (valid_s3) begin
			tag_s4 <= tag_s3;
			acc_s4 <= tag_s3.first ? SW'(sq_s3) : acc_s4 + SW'(sq_s3);
		end
	end

	// ------------------------------------------------------------------
	// Sequencer, configuration registers and result register
	// ------------------------------------------------------------------
	logic                   out_free;
	logic                   emit_last;
	logic [RW+ROW_BITS-1:0] best_wide;
	logic [DW+COL_BITS-1:0] emit_wide;

	assign out_free  = !out_valid_q || !out_stall;
	assign emit_last = (emit_d_q == dims_last);
	assign best_wide = (RW + ROW_BITS)'(best_row_q);
	assign emit_wide = (DW + COL_BITS)'(emit_d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_rows_q  <= ROWS_RESET;
			cfg_dims_q  <= DIMS_RESET;
			scan_row_q  <= '0;
			scan_d_q    <= '0;
			emit_d_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROWS_IN_USE: cfg_rows_q <= cfg_data[ROWS_CFG_BITS-1:0];
					CFG_DIMS_IN_USE: cfg_dims_q <= cfg_data[DIMS_CFG_BITS-1:0];
					default: ;
				endcase
			end

			// Drop the result once the consumer takes it, unless the next one
			// loads in the same cycle.
			if (out_valid_q && !out_stall && (state_q != S_EMIT_LD)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (start_search) begin
						scan_row_q <= '0;
						scan_d_q   <= '0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					// Advance one element per cycle, row-major.
					if (scan_end_d) begin
						scan_d_q <= '0;
						if (scan_end_r) begin
							state_q <= S_DRAIN;
						end else begin
							scan_row_q <= scan_row_q + 1'b1;
						end
					end else begin
						scan_d_q <= scan_d_q + 1'b1;
					end
				end
				S_DRAIN: begin
					// Hold until the last row sum has been compared.
					if (pipe_empty) begin
						emit_d_q <= '0;
						state_q  <= S_EMIT_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						match_index_q <= best_wide[ROW_BITS-1:0];
						out_column_q  <= emit_wide[COL_BITS-1:0];
						out_value_q   <= cb_rdata;
						last_q        <= emit_last;
						if (emit_last) begin
							state_q <= S_IDLE;
						end else begin
							emit_d_q <= emit_d_q + 1'b1;
							state_q  <= S_EMIT_RD;
						end
					end else begin
						out_valid_q <= out_valid_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign match_index = match_index_q;
	assign out_column  = out_column_q;
	assign out_value   = out_value_q;
	assign last        = last_q;

endmodule

`default_nettype wire
